// ----- rtl/core/cdnc_pkg.sv -----
`default_nettype none

package cdnc_pkg;

  // Pipeline depth (register stages from input to output register)
  localparam int NumStages = 10;

  // Field widths
  localparam int KeyW      = 27;
  localparam int DayW      = 23;
  localparam int InTdataW  = 56;
  localparam int OutTdataW = 56;

  // Action codes carried on tuser
  localparam logic ActKeyToDay = 1'b0;
  localparam logic ActDayToKey = 1'b1;

  // Reciprocal multipliers (round-up constants, exact over the operand widths used)
  // n / 10000 for n < 2^27: (n >> 4) * M >> 33
  localparam logic [23:0] Div10kMul   = 24'd13743896;
  // n / 100 for n < 2^14: n * M >> 21
  localparam logic [14:0] Div100Mul   = 15'd20972;
  // n / 400 for n < 2^14: (n >> 4) * M >> 15
  localparam logic [10:0] Div25Mul    = 11'd1311;
  // n / 5 for n < 2^14: n * M >> 17
  localparam logic [14:0] Div5Mul     = 15'd26215;
  // n / 146097 for n < 2^24: n * M >> 42
  localparam logic [24:0] DivEraMul   = 25'd30103606;
  // n / 1460 for n < 2^18: (n >> 2) * M >> 25
  localparam logic [16:0] Div1460Mul  = 17'd91930;
  // n / 365 for n < 2^18: n * M >> 27
  localparam logic [18:0] Div365Mul   = 19'd367720;
  // n / 153 for n < 2^11: n * M >> 19
  localparam logic [11:0] Div153Mul   = 12'd3427;

  // Calendar constants
  localparam logic [22:0] DaysPerEra  = 23'd146097;
  // era shift (one era) + days to epoch + one (day-of-year is carried plus one)
  localparam logic [22:0] KeyDayBias  = 23'd865566;
  // day count bias: days to epoch + 25 eras, keeps the era index positive
  localparam logic [23:0] DayEraBias  = 24'd4371893;
  // 25 eras of 400 years, times 10000
  localparam logic [26:0] KeyYearBias = 27'd100000000;

  // Control from the pipeline sequencer to the datapaths
  typedef logic [NumStages-1:0] stage_vec_t;

  typedef struct packed {
    stage_vec_t en;       // per-stage load enable
    logic       act_out;  // action of the item in the output register
  } pipe_ctl_t;

  // year-of-era / 100 for year-of-era below 400
  function automatic logic [1:0] div100_yoe(input logic [8:0] yoe);
    logic [1:0] r;
    if (yoe >= 9'd300) begin
      r = 2'd3;
    end else if (yoe >= 9'd200) begin
      r = 2'd2;
    end else if (yoe >= 9'd100) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  // day-of-era / 36524 for day-of-era below 146097
  function automatic logic [2:0] div36524_doe(input logic [17:0] doe);
    logic [2:0] r;
    if (doe >= 18'd146096) begin
      r = 3'd4;
    end else if (doe >= 18'd109572) begin
      r = 3'd3;
    end else if (doe >= 18'd73048) begin
      r = 3'd2;
    end else if (doe >= 18'd36524) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // (153 * mp + 2) / 5: first day of month index mp, March based
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cdnc_pipe_ctrl.sv -----
`default_nettype none

module cdnc_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_act_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cdnc_pkg::pipe_ctl_t ctl_o
);
  import cdnc_pkg::*;

  stage_vec_t           valid_q, valid_d;
  stage_vec_t           act_q;
  stage_vec_t           en;
  stage_vec_t           in_v;
  stage_vec_t           act_in;
  logic [NumStages:0]   rdy;

  // Per-stage ready: a stage takes data when empty or when it drains
  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign in_v    = {valid_q[NumStages-2:0], in_valid_i};
  assign act_in  = {act_q[NumStages-2:0], in_act_i};
  assign en      = rdy[NumStages-1:0] & in_v;
  assign valid_d = en | (valid_q & ~rdy[NumStages-1:0]);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Action tag travels with the item
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        act_q[k] <= act_in[k];
      end
    end
  end

  assign in_ready_o    = rdy[0];
  assign out_valid_o   = valid_q[NumStages-1];
  assign ctl_o.en      = en;
  assign ctl_o.act_out = act_q[NumStages-1];

  logic acc_in, acc_out;
  assign acc_in  = in_valid_i & in_ready_o;
  assign acc_out = out_valid_o & out_ready_i;

  // Occupancy grows by one on input-only transfers
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && !acc_out) |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("pipeline occupancy did not grow on input transfer");

  // Occupancy shrinks by one on output-only transfers
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!acc_in && acc_out) |=> ($countones(valid_q) == $past($countones(valid_q)) - 1))
    else $error("pipeline occupancy did not shrink on output transfer");

  // Occupancy holds otherwise
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in == acc_out) |=> ($countones(valid_q) == $past($countones(valid_q))))
    else $error("pipeline occupancy changed without net transfer");

  // A ready sink propagates back to the input
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("ready chain broken");

endmodule

`default_nettype wire

// ----- rtl/core/cdnc_key2day.sv -----
`default_nettype none

module cdnc_key2day (
  input  logic                          clk_i,
  input  cdnc_pkg::stage_vec_t          en_i,
  input  logic [cdnc_pkg::KeyW-1:0]     key_i,
  output logic [cdnc_pkg::DayW-1:0]     day_o
);
  import cdnc_pkg::*;

  // Stage 1: year = key / 10000
  logic [46:0] y0_prod;
  logic [26:0] s1_key_q;
  logic [13:0] s1_y0_q;

  assign y0_prod = 47'(key_i[26:4]) * 47'(Div10kMul);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_key_q <= key_i;
      s1_y0_q  <= y0_prod[46:33];
    end
  end

  // Stage 2: month-day part = key - year * 10000
  logic [26:0] rem_full;
  logic [13:0] s2_rem_q;
  logic [13:0] s2_y0_q;

  assign rem_full = s1_key_q - 27'(s1_y0_q) * 27'd10000;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_rem_q <= rem_full[13:0];
      s2_y0_q  <= s1_y0_q;
    end
  end

  // Stage 3: month = rem / 100
  logic [28:0] m_prod;
  logic [6:0]  s3_m_q;
  logic [13:0] s3_rem_q;
  logic [13:0] s3_y0_q;

  assign m_prod = 29'(s2_rem_q) * 29'(Div100Mul);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_m_q   <= m_prod[27:21];
      s3_rem_q <= s2_rem_q;
      s3_y0_q  <= s2_y0_q;
    end
  end

  // Stage 4: day, March-based month, year shifted by one era (non-negative)
  logic [13:0] d_full;
  logic        m_le2;
  logic [6:0]  mm;
  logic [13:0] yy;
  logic [6:0]  s4_d_q;
  logic [6:0]  s4_mm_q;
  logic [13:0] s4_yy_q;

  assign d_full = s3_rem_q - 14'(s3_m_q) * 14'd100;
  assign m_le2  = (s3_m_q <= 7'd2);
  assign mm     = m_le2 ? (s3_m_q + 7'd9) : (s3_m_q - 7'd3);
  assign yy     = s3_y0_q + 14'd400 - 14'(m_le2);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_d_q  <= d_full[6:0];
      s4_mm_q <= mm;
      s4_yy_q <= yy;
    end
  end

  // Stage 5: era + 1 = yy / 400, month term numerator
  logic [20:0] p_prod;
  logic [13:0] v;
  logic [5:0]  s5_p_q;
  logic [13:0] s5_v_q;
  logic [13:0] s5_yy_q;
  logic [6:0]  s5_d_q;

  assign p_prod = 21'(s4_yy_q[13:4]) * 21'(Div25Mul);
  assign v      = 14'(s4_mm_q) * 14'd153 + 14'd2;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_p_q  <= p_prod[20:15];
      s5_v_q  <= v;
      s5_yy_q <= s4_yy_q;
      s5_d_q  <= s4_d_q;
    end
  end

  // Stage 6: year of era, month start day
  logic [13:0] yoe_full;
  logic [28:0] w_prod;
  logic [8:0]  s6_yoe_q;
  logic [11:0] s6_w_q;
  logic [6:0]  s6_d_q;
  logic [5:0]  s6_p_q;

  assign yoe_full = s5_yy_q - 14'(s5_p_q) * 14'd400;
  assign w_prod   = 29'(s5_v_q) * 29'(Div5Mul);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_yoe_q <= yoe_full[8:0];
      s6_w_q   <= w_prod[28:17];
      s6_d_q   <= s5_d_q;
      s6_p_q   <= s5_p_q;
    end
  end

  // Stage 7: day of era plus one
  logic [17:0] doe1;
  logic [17:0] s7_doe_q;
  logic [5:0]  s7_p_q;

  assign doe1 = 18'(s6_yoe_q) * 18'd365 + 18'(s6_yoe_q[8:2])
              - 18'(div100_yoe(s6_yoe_q)) + 18'(s6_w_q) + 18'(s6_d_q);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s7_doe_q <= doe1;
      s7_p_q   <= s6_p_q;
    end
  end

  // Stage 8: day number, wrapped to 23 bits
  logic [22:0] res;
  logic [22:0] s8_res_q;

  assign res = 23'(s7_p_q) * DaysPerEra + 23'(s7_doe_q) - KeyDayBias;

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s8_res_q <= res;
    end
  end

  // Stages 9 and 10: align with the other direction
  logic [22:0] s9_res_q;
  logic [22:0] s10_res_q;

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s9_res_q <= s8_res_q;
    end
    if (en_i[9]) begin
      s10_res_q <= s9_res_q;
    end
  end

  assign day_o = s10_res_q;

endmodule

`default_nettype wire

// ----- rtl/core/cdnc_day2key.sv -----
`default_nettype none

module cdnc_day2key (
  input  logic                             clk_i,
  input  cdnc_pkg::stage_vec_t             en_i,
  input  logic signed [cdnc_pkg::DayW-1:0] dc_i,
  output logic [cdnc_pkg::KeyW-1:0]        key_o
);
  import cdnc_pkg::*;

  // Stage 1: biased day count, always positive
  logic [23:0] zz;
  logic [23:0] s1_zz_q;

  assign zz = 24'(dc_i) + DayEraBias;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_zz_q <= zz;
    end
  end

  // Stage 2: era index = zz / 146097
  logic [48:0] q_prod;
  logic [5:0]  s2_q_q;
  logic [23:0] s2_zz_q;

  assign q_prod = 49'(s1_zz_q) * 49'(DivEraMul);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q_q  <= q_prod[47:42];
      s2_zz_q <= s1_zz_q;
    end
  end

  // Stage 3: day of era
  logic [23:0] doe_full;
  logic [17:0] s3_doe_q;
  logic [5:0]  s3_q_q;

  assign doe_full = s2_zz_q - 24'(s2_q_q) * 24'(DaysPerEra);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_doe_q <= doe_full[17:0];
      s3_q_q   <= s2_q_q;
    end
  end

  // Stage 4: leap corrections of the day of era
  logic [32:0] c1460_prod;
  logic [6:0]  s4_c1460_q;
  logic [2:0]  s4_c36524_q;
  logic        s4_cend_q;
  logic [17:0] s4_doe_q;
  logic [5:0]  s4_q_q;

  assign c1460_prod = 33'(s3_doe_q[17:2]) * 33'(Div1460Mul);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_c1460_q  <= c1460_prod[31:25];
      s4_c36524_q <= div36524_doe(s3_doe_q);
      s4_cend_q   <= (s3_doe_q == 18'd146096);
      s4_doe_q    <= s3_doe_q;
      s4_q_q      <= s3_q_q;
    end
  end

  // Stage 5: corrected day of era
  logic [17:0] t;
  logic [17:0] s5_t_q;
  logic [17:0] s5_doe_q;
  logic [5:0]  s5_q_q;

  assign t = s4_doe_q - 18'(s4_c1460_q) + 18'(s4_c36524_q) - 18'(s4_cend_q);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_t_q   <= t;
      s5_doe_q <= s4_doe_q;
      s5_q_q   <= s4_q_q;
    end
  end

  // Stage 6: year of era = t / 365
  logic [36:0] yoe_prod;
  logic [8:0]  s6_yoe_q;
  logic [17:0] s6_doe_q;
  logic [5:0]  s6_q_q;

  assign yoe_prod = 37'(s5_t_q) * 37'(Div365Mul);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_yoe_q <= yoe_prod[35:27];
      s6_doe_q <= s5_doe_q;
      s6_q_q   <= s5_q_q;
    end
  end

  // Stage 7: day of year, March based
  logic [17:0] doy_full;
  logic [8:0]  s7_doy_q;
  logic [8:0]  s7_yoe_q;
  logic [5:0]  s7_q_q;

  assign doy_full = s6_doe_q - (18'(s6_yoe_q) * 18'd365 + 18'(s6_yoe_q[8:2])
                  - 18'(div100_yoe(s6_yoe_q)));

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s7_doy_q <= doy_full[8:0];
      s7_yoe_q <= s6_yoe_q;
      s7_q_q   <= s6_q_q;
    end
  end

  // Stage 8: March-based month = (5 * doy + 2) / 153
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [3:0]  s8_mp_q;
  logic [8:0]  s8_doy_q;
  logic [8:0]  s8_yoe_q;
  logic [5:0]  s8_q_q;

  assign mp_num  = 11'(s7_doy_q) * 11'd5 + 11'd2;
  assign mp_prod = 23'(mp_num) * 23'(Div153Mul);

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s8_mp_q  <= mp_prod[22:19];
      s8_doy_q <= s7_doy_q;
      s8_yoe_q <= s7_yoe_q;
      s8_q_q   <= s7_q_q;
    end
  end

  // Stage 9: day, civil month, biased year
  logic [8:0]  d_full;
  logic [3:0]  m;
  logic        m_le2;
  logic [14:0] ybase;
  logic [4:0]  s9_d_q;
  logic [3:0]  s9_m_q;
  logic [14:0] s9_y_q;

  assign d_full = s8_doy_q - month_start(s8_mp_q) + 9'd1;
  assign m      = (s8_mp_q < 4'd10) ? (s8_mp_q + 4'd3) : (s8_mp_q - 4'd9);
  assign m_le2  = (m <= 4'd2);
  assign ybase  = 15'(s8_yoe_q) + 15'(s8_q_q) * 15'd400 + 15'(m_le2);

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s9_d_q <= d_full[4:0];
      s9_m_q <= m;
      s9_y_q <= ybase;
    end
  end

  // Stage 10: packed decimal key, wrapped to 27 bits
  logic [26:0] key;
  logic [26:0] s10_key_q;

  assign key = 27'(s9_y_q) * 27'd10000 + 27'(s9_m_q) * 27'd100 + 27'(s9_d_q)
             - KeyYearBias;

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      s10_key_q <= key;
    end
  end

  assign key_o = s10_key_q;

endmodule

`default_nettype wire

// ----- rtl/core/civil_date_day_number_convert_core.sv -----
`default_nettype none

// Channel   Dir  Signals                   Contents
// s_axis    in   tvalid/tready/tdata/tuser  tdata: ymd_key, day_count; tuser: action
// m_axis    out  tvalid/tready/tdata        tdata: day_result, key_result
//
// One transfer per cycle is sustained in both directions while m_axis_tready is
// high. The datapath has ten stages (constant-reciprocal multiplies spread
// across the stages). Reset clears only the stage valid bits.
// Each stage has its own ready, so bubbles close up under a stalled output and
// input transfers continue until every stage holds an item.

module civil_date_day_number_convert_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [26:0] ymd_key, [49:27] day_count, [55:50] zero
  input  logic [cdnc_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [0] action
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [22:0] day_result, [49:23] key_result, [55:50] zero
  output logic [cdnc_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import cdnc_pkg::*;

  pipe_ctl_t         ctl;
  logic [KeyW-1:0]   key_in;
  logic signed [DayW-1:0] dc_in;
  logic [DayW-1:0]   day_res;
  logic [KeyW-1:0]   key_res;
  logic [DayW-1:0]   day_out;
  logic [KeyW-1:0]   key_out;

  assign key_in = s_axis_tdata_i[26:0];
  assign dc_in  = $signed(s_axis_tdata_i[49:27]);

  // Stage sequencing and valid tracking
  cdnc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_act_i    (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .ctl_o       (ctl)
  );

  // Date key to day number
  cdnc_key2day u_key2day (
    .clk_i (clk_i),
    .en_i  (ctl.en),
    .key_i (key_in),
    .day_o (day_res)
  );

  // Day number to date key
  cdnc_day2key u_day2key (
    .clk_i (clk_i),
    .en_i  (ctl.en),
    .dc_i  (dc_in),
    .key_o (key_res)
  );

  // The field of the direction not selected is driven to zero
  assign day_out = (ctl.act_out == ActKeyToDay) ? day_res : '0;
  assign key_out = (ctl.act_out == ActDayToKey) ? key_res : '0;

  assign m_axis_tdata_o = {6'd0, key_out, day_out};

endmodule

`default_nettype wire

// ----- verif/tb_civil_date_day_number_convert_core.sv -----
module tb_civil_date_day_number_convert_core;
  import cdnc_pkg::*;

  localparam longint EpochOffset = 719468;  // days from 0000-03-01 to 1970-01-01
  localparam longint EraDays     = 146097;  // days in 400 Gregorian years
  localparam int     ItemsPerPhase = 660;
  localparam int     CycleLimit    = 400000;

  typedef struct packed {
    logic [DayW-1:0] day_result;
    logic [KeyW-1:0] key_result;
  } conv_result_t;

  // Expected-result store plus calendar predictor
  class conversion_scoreboard;
    conv_result_t expected_q[$];
    int n_errors;
    int n_checked;
    int n_to_days;
    int n_to_keys;

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q -= 1;
      return q;
    endfunction

    // YYYYMMDD -> days since epoch, wrapped to the result width
    function logic [DayW-1:0] days_of_key(logic [KeyW-1:0] key);
      longint k, yr, mo, dy, era, yoe, doy, doe, total;
      k  = key;
      yr = k / 10000;
      mo = (k / 100) % 100;
      dy = k % 100;
      // Jan/Feb (and bogus month 0) belong to the previous March-based year
      if (mo <= 2) yr -= 1;
      era   = floor_div(yr, 400);
      yoe   = yr - era * 400;
      doy   = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
      doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      total = era * EraDays + doe - EpochOffset;
      return total[DayW-1:0];
    endfunction

    // days since epoch -> YYYYMMDD, wrapped to the result width
    function logic [KeyW-1:0] key_of_days(logic signed [DayW-1:0] days);
      longint z, era, doe, yoe, yr, doy, mp, dy, mo, packed_key;
      z   = days;
      z  += EpochOffset;
      era = floor_div(z, EraDays);
      doe = z - era * EraDays;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr  = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      dy  = doy - (153 * mp + 2) / 5 + 1;
      mo  = mp < 10 ? mp + 3 : mp - 9;
      if (mo <= 2) yr += 1;
      packed_key = yr * 10000 + mo * 100 + dy;
      return packed_key[KeyW-1:0];
    endfunction

    function void note_input(logic act, logic [KeyW-1:0] key, logic [DayW-1:0] days);
      conv_result_t r;
      r = '0;
      if (act == ActKeyToDay) begin
        r.day_result = days_of_key(key);
        n_to_days++;
      end else begin
        r.key_result = key_of_days(days);
        n_to_keys++;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OutTdataW-1:0] data);
      conv_result_t r;
      logic [DayW-1:0] got_day;
      logic [KeyW-1:0] got_key;
      logic [OutTdataW-DayW-KeyW-1:0] got_pad;
      got_day = data[DayW-1:0];
      got_key = data[DayW+KeyW-1:DayW];
      got_pad = data[OutTdataW-1:DayW+KeyW];
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer, tdata 0x%0h", data);
        n_errors++;
        return;
      end
      r = expected_q.pop_front();
      n_checked++;
      if (got_day !== r.day_result) begin
        $error("day_result: expected %0d, got %0d", $signed(r.day_result), $signed(got_day));
        n_errors++;
      end
      if (got_key !== r.key_result) begin
        $error("key_result: expected %0d, got %0d", r.key_result, got_key);
        n_errors++;
      end
      if (got_pad !== '0) begin
        $error("tdata pad: expected 0, got 0x%0h", got_pad);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [InTdataW-1:0]  s_data = '0;
  logic                 s_user = 1'b0;
  logic                 m_ready = 1'b0;
  wire                  s_ready;
  wire                  m_valid;
  wire [OutTdataW-1:0]  m_data;

  int src_idle_pct = 21;
  int dst_idle_pct = 60;
  int cycle_count  = 0;

  conversion_scoreboard sb = new();

  civil_date_day_number_convert_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random backpressure, check every accepted transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data);
    m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(logic act, logic [KeyW-1:0] key, logic [DayW-1:0] days);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= {{(InTdataW-DayW-KeyW){1'b0}}, days, key};
    do @(posedge clk_i); while (!s_ready);
    sb.note_input(act, key, days);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic            act;
    logic [KeyW-1:0] key;
    logic [DayW-1:0] days;
    int              yr, mo, dy, dval;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, epoch, leap days, odd month/day fields, year overflow
    send_item(ActKeyToDay, 27'd101, 23'd0);
    send_item(ActKeyToDay, 27'd99991231, 23'd0);
    send_item(ActKeyToDay, 27'd19700101, 23'd0);
    send_item(ActKeyToDay, 27'd20000229, 23'd0);
    send_item(ActKeyToDay, 27'd19000301, 23'd0);
    send_item(ActKeyToDay, 27'd20240115, 23'd0);
    send_item(ActKeyToDay, 27'd20240228, 23'd0);
    send_item(ActKeyToDay, 27'd20230000, 23'd0);
    send_item(ActKeyToDay, 27'd20239999, 23'd0);
    send_item(ActKeyToDay, 27'd20231305, 23'd0);
    send_item(ActKeyToDay, 27'd0, '1);
    send_item(ActKeyToDay, '1, '1);
    send_item(ActDayToKey, '1, -23'sd719528);
    send_item(ActDayToKey, '0, 23'sd2932896);
    send_item(ActDayToKey, '0, 23'sd0);
    send_item(ActDayToKey, '0, -23'sd1);
    send_item(ActDayToKey, '0, 23'sd11016);
    send_item(ActDayToKey, '0, 23'sd11017);
    send_item(ActDayToKey, '0, -23'sd719529);
    send_item(ActDayToKey, '0, 23'sd2932897);
    send_item(ActDayToKey, '0, 23'h400000);
    send_item(ActDayToKey, '1, 23'h3FFFFF);
    wait_drained();

    // Random: mostly calendar-valid values, some raw bit patterns
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 60 : 0;
      dst_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 21 : 0;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        act = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 7) begin
          yr  = $urandom_range(0, 9999);
          mo  = $urandom_range(1, 12);
          dy  = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
          key = KeyW'(yr * 10000 + mo * 100 + dy);
        end else begin
          key = KeyW'($urandom);
        end
        if ($urandom_range(0, 9) < 7) begin
          dval = int'($urandom_range(0, 3652424)) - 719528;
          days = dval[DayW-1:0];
        end else begin
          days = DayW'($urandom);
        end
        send_item(act, key, days);
      end
      // hold the source off until the pipe is empty
      if (phase == 1) wait_drained();
    end

    wait_drained();
    repeat (3 * NumStages) @(posedge clk_i);

    $display("covered %0d date-to-day and %0d day-to-date transfers under three idle mixes",
             sb.n_to_days, sb.n_to_keys);
    $display("%0d results checked, %0d errors", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- civil_date_day_number_convert_core.f -----
rtl/core/cdnc_pkg.sv
rtl/core/cdnc_pipe_ctrl.sv
rtl/core/cdnc_key2day.sv
rtl/core/cdnc_day2key.sv
rtl/core/civil_date_day_number_convert_core.sv
verif/tb_civil_date_day_number_convert_core.sv
